>>> hw/rtl/pas_pkg.sv
package pas_pkg;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int RAND_W   = 16;
  localparam int NODE_F_W = 10;
  localparam int COUNT_W  = 11;
  localparam int TOP_W    = 16;
  localparam int SUM_W    = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 80;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_ADD_NODE   = 2'd0;
  localparam op_t OP_UNDIRECTED = 2'd1;
  localparam op_t OP_DIRECTED   = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_NONE  = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  localparam int START_NODES = 3;

endpackage

>>> hw/rtl/preferential_attachment_sampler.sv
// Preferential attachment sampler over a table of node degrees.
// Input beats: in_tuser holds the operation (add node, undirected edge,
// directed edge); in_tdata holds the random fraction, source and destination.
// Each accepted beat gives exactly one result beat on the out_ channel with
// the status, the edge ends and the running totals after the operation.
// The user must write the node limit on the cfg_ channel only while the
// block is idle; the block does not enforce this. It works on one beat at
// a time. An edge operation reads and writes back the source degree entry,
// then for an undirected edge the destination entry, before the result.
// An add-node operation scans the degree memory one entry per cycle from
// node 0 through the single read port. Checks that fail (graph full, zero
// total, bad index) go straight to the result. After reset the degree
// memory is cleared one entry per cycle; input beats are held off
// meanwhile, the cfg_ channel is always ready. When the receiver stalls,
// the result waits in the output register and the block holds before
// loading the next result.
module preferential_attachment_sampler #(
  parameter int MAX_NODES   = 1024,
  parameter int DEGREE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pas_pkg::COUNT_W-1:0]    cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata: random_fraction, source_node, dest_node, zero pad
  input  logic [pas_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: operation
  input  logic [pas_pkg::OP_W-1:0]       in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tdata: edge_source, edge_dest, top_degree, degree_sum, nodes_in_use, zero pad
  output logic [pas_pkg::OUT_DATA_W-1:0] out_tdata,
  // tuser: status
  output logic [pas_pkg::STATUS_W-1:0]   out_tuser
);
  import pas_pkg::*;

  localparam int IDX_W   = $clog2(MAX_NODES);
  localparam int NODE_W  = $clog2(MAX_NODES + 1);
  localparam int CUM_W   = DEGREE_BITS + NODE_W;
  localparam int LHS_W   = RAND_W + SUM_W;
  localparam int CUMS_W  = CUM_W + RAND_W;
  localparam int WIDE_W  = (LHS_W > CUMS_W) ? LHS_W : CUMS_W;
  localparam int TCMP_W  = (CUM_W > SUM_W) ? CUM_W : SUM_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_RD_A  = 3'd3;
  localparam logic [2:0] S_WR_A  = 3'd4;
  localparam logic [2:0] S_RD_B  = 3'd5;
  localparam logic [2:0] S_WR_B  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [DEGREE_BITS-1:0] DEG_MAX = '1;

  logic [2:0]             state_r, state_nxt;
  logic [NODE_W-1:0]      clr_idx_r, clr_idx_nxt;
  logic [COUNT_W-1:0]     node_limit_r;
  logic [SUM_W-1:0]       total_r, total_nxt;
  logic [NODE_W-1:0]      node_count_r, node_count_nxt;
  logic [DEGREE_BITS-1:0] highest_r, highest_nxt;
  logic [LHS_W-1:0]       lhs_r, lhs_nxt;
  logic [CUM_W-1:0]       cum_r, cum_nxt;
  logic [NODE_W-1:0]      iss_idx_r, iss_idx_nxt;
  logic [NODE_W-1:0]      proc_idx_r, proc_idx_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]       a_addr_r, a_addr_nxt;
  logic [IDX_W-1:0]       b_addr_r, b_addr_nxt;
  logic                   has_b_r, has_b_nxt;
  logic [1:0]             tot_inc_r, tot_inc_nxt;
  logic                   add_node_r, add_node_nxt;
  status_t                status_r, status_nxt;
  logic [NODE_F_W-1:0]    es_r, es_nxt;
  logic [NODE_F_W-1:0]    ed_r, ed_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  status_t                out_user_r, out_user_nxt;

  logic [DEGREE_BITS-1:0] deg_mem [MAX_NODES];
  logic [DEGREE_BITS-1:0] mem_rdata_r;
  logic                   mem_we, mem_re;
  logic [IDX_W-1:0]       mem_waddr, mem_raddr;
  logic [DEGREE_BITS-1:0] mem_wdata;

  op_t                    in_op;
  logic [RAND_W-1:0]      in_rand;
  logic [NODE_F_W-1:0]    in_src, in_dst;
  logic [31:0]            lim32, src32, dst32, node32, proc32, high32;
  logic                   accept;
  logic                   hit;
  logic [DEGREE_BITS-1:0] deg_inc;
  logic [SUM_W:0]         total_sum;

  assign in_op   = in_tuser;
  assign in_rand = in_tdata[15:0];
  assign in_src  = in_tdata[25:16];
  assign in_dst  = in_tdata[35:26];

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign lim32  = (32'(node_limit_r) < 32'(MAX_NODES)) ? 32'(node_limit_r) : 32'(MAX_NODES);
  assign src32  = 32'(in_src);
  assign dst32  = 32'(in_dst);
  assign node32 = 32'(node_count_r);
  assign proc32 = 32'(proc_idx_r);
  assign high32 = 32'(highest_r);

  assign cum_nxt = cum_r + CUM_W'(mem_rdata_r);
  assign hit = (TCMP_W'(cum_nxt) >= TCMP_W'(total_r)) ||
               (WIDE_W'(lhs_r) <= (WIDE_W'(cum_nxt) << RAND_W));
  assign deg_inc = (mem_rdata_r == DEG_MAX) ? mem_rdata_r : mem_rdata_r + 1'b1;
  assign total_sum = {1'b0, total_r} + (SUM_W + 1)'(tot_inc_r);

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    total_nxt      = total_r;
    node_count_nxt = node_count_r;
    highest_nxt    = highest_r;
    lhs_nxt        = lhs_r;
    iss_idx_nxt    = iss_idx_r;
    proc_idx_nxt   = proc_idx_r;
    rd_vld_nxt     = 1'b0;
    a_addr_nxt     = a_addr_r;
    b_addr_nxt     = b_addr_r;
    has_b_nxt      = has_b_r;
    tot_inc_nxt    = tot_inc_r;
    add_node_nxt   = add_node_r;
    status_nxt     = status_r;
    es_nxt         = es_r;
    ed_nxt         = ed_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    mem_we         = 1'b0;
    mem_waddr      = a_addr_r;
    mem_wdata      = deg_inc;
    mem_re         = 1'b0;
    mem_raddr      = a_addr_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r[IDX_W-1:0];
        mem_wdata   = '0;
        clr_idx_nxt = clr_idx_r + NODE_W'(1);
        if (clr_idx_r == NODE_W'(MAX_NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          status_nxt   = ST_OK;
          es_nxt       = '0;
          ed_nxt       = '0;
          add_node_nxt = 1'b0;
          has_b_nxt    = 1'b0;
          state_nxt    = S_DONE;
          priority if (in_op == OP_ADD_NODE) begin
            priority if (node32 >= lim32) begin
              status_nxt = ST_FULL;
            end else if (total_r == '0) begin
              status_nxt = ST_NONE;
            end else begin
              lhs_nxt      = LHS_W'(in_rand) * LHS_W'(total_r);
              iss_idx_nxt  = '0;
              proc_idx_nxt = '0;
              b_addr_nxt   = node32[IDX_W-1:0];
              state_nxt    = S_SCAN;
            end
          end else if (in_op == OP_UNDIRECTED || in_op == OP_DIRECTED) begin
            if (src32 >= lim32 || dst32 >= lim32) begin
              status_nxt = ST_RANGE;
            end else begin
              a_addr_nxt  = src32[IDX_W-1:0];
              b_addr_nxt  = dst32[IDX_W-1:0];
              has_b_nxt   = (in_op == OP_UNDIRECTED);
              tot_inc_nxt = (in_op == OP_UNDIRECTED) ? 2'd2 : 2'd1;
              es_nxt      = in_src;
              ed_nxt      = in_dst;
              state_nxt   = S_RD_A;
            end
          end else begin
            status_nxt = ST_RANGE;
          end
        end
      end
      S_SCAN: begin
        if (iss_idx_r < node_count_r) begin
          mem_re      = 1'b1;
          mem_raddr   = iss_idx_r[IDX_W-1:0];
          rd_vld_nxt  = 1'b1;
          iss_idx_nxt = iss_idx_r + NODE_W'(1);
        end
        if (rd_vld_r) begin
          proc_idx_nxt = proc_idx_r + NODE_W'(1);
          priority if (hit) begin
            rd_vld_nxt   = 1'b0;
            a_addr_nxt   = proc32[IDX_W-1:0];
            has_b_nxt    = 1'b1;
            tot_inc_nxt  = 2'd2;
            add_node_nxt = 1'b1;
            es_nxt       = proc32[NODE_F_W-1:0];
            ed_nxt       = node32[NODE_F_W-1:0];
            state_nxt    = S_RD_A;
          end else if ((proc_idx_r + NODE_W'(1)) == node_count_r) begin
            rd_vld_nxt = 1'b0;
            status_nxt = ST_NONE;
            state_nxt  = S_DONE;
          end else begin
          end
        end
      end
      S_RD_A: begin
        mem_re    = 1'b1;
        mem_raddr = a_addr_r;
        state_nxt = S_WR_A;
      end
      S_WR_A: begin
        mem_we    = 1'b1;
        mem_waddr = a_addr_r;
        if (deg_inc > highest_r) begin
          highest_nxt = deg_inc;
        end
        total_nxt = total_sum[SUM_W] ? '1 : total_sum[SUM_W-1:0];
        if (add_node_r) begin
          node_count_nxt = node_count_r + NODE_W'(1);
        end
        state_nxt = has_b_r ? S_RD_B : S_DONE;
      end
      S_RD_B: begin
        mem_re    = 1'b1;
        mem_raddr = b_addr_r;
        state_nxt = S_WR_B;
      end
      S_WR_B: begin
        mem_we    = 1'b1;
        mem_waddr = b_addr_r;
        if (deg_inc > highest_r) begin
          highest_nxt = deg_inc;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = status_r;
          out_data_nxt  = {1'b0, node32[COUNT_W-1:0], total_r, high32[TOP_W-1:0], ed_r, es_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      node_limit_r <= COUNT_W'(1024);
      total_r      <= '0;
      node_count_r <= NODE_W'(START_NODES);
      highest_r    <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      total_r      <= total_nxt;
      node_count_r <= node_count_nxt;
      highest_r    <= highest_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        node_limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lhs_r      <= lhs_nxt;
    cum_r      <= (state_r == S_SCAN && rd_vld_r) ? cum_nxt :
                  (state_r == S_SCAN) ? cum_r : '0;
    iss_idx_r  <= iss_idx_nxt;
    proc_idx_r <= proc_idx_nxt;
    a_addr_r   <= a_addr_nxt;
    b_addr_r   <= b_addr_nxt;
    has_b_r    <= has_b_nxt;
    tot_inc_r  <= tot_inc_nxt;
    add_node_r <= add_node_nxt;
    status_r   <= status_nxt;
    es_r       <= es_nxt;
    ed_r       <= ed_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      deg_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= deg_mem[mem_raddr];
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("second beat accepted while an operation is in progress");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> total_r >= $past(total_r))
    else $error("total degree decreased");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && node_count_r != $past(node_count_r)) |->
      (node_count_r == $past(node_count_r) + NODE_W'(1)))
    else $error("node count changed by other than one");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (32'(node_count_r) < 32'(MAX_NODES)))
    else $error("scan started on a full table");

endmodule
